// ----- sv/json_string_unescaper_defines.svh -----
// Assertion macros shared by the JSON string unescaper modules.
`ifndef JSON_STRING_UNESCAPER_DEFINES_SVH
`define JSON_STRING_UNESCAPER_DEFINES_SVH

`ifndef SYNTH
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define JSU_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define JSU_ASSERT(lbl, prop, msg)
`define JSU_NEVER(lbl, cond, msg)
`endif

`endif

// ----- sv/jsu_pkg.sv -----
// Shared types and constants of the JSON string unescaper.
package jsu_pkg;

  localparam int LEN_W   = 16;
  localparam int CAP_W   = 16;
  localparam int OUT_LEN_W = 16;
  localparam int LIM_W   = ((LEN_W > CAP_W) ? LEN_W : CAP_W) + 1;
  localparam logic [LEN_W-1:0] CNT_MAX = {LEN_W{1'b1}};

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [0:0] CFG_COUNT_ONLY = 1'b0;
  localparam logic [0:0] CFG_CAPACITY   = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic              count_only;
    logic [CAP_W-1:0]  capacity;
  } cfg_t;

  // Results caused by one input byte: data bytes first, then an optional terminal result.
  typedef struct packed {
    logic [2:0]            ndata;
    logic [3:0][7:0]       bytes;
    logic                  has_term;
    kind_t                 term_kind;
    status_t               term_status;
    logic [OUT_LEN_W-1:0]  base;
    logic [OUT_LEN_W-1:0]  fin;
  } entry_t;

endpackage

// ----- sv/json_string_unescaper.sv -----
// Top level of the JSON string unescaper: config registers, parser, queue, serializer.
//
// channel  | handshake            | payload
// input    | in_valid / in_ready  | text_byte, end_of_buffer
// result   | out_valid / out_ready| result_kind, out_byte, status, decoded_length, last
// config   | cfg_write            | cfg_index, cfg_data
//
// One input byte per cycle while the four-entry queue has room.
// A byte yields up to five results; serializer sends one per cycle unless stalled.
// A full queue stalls input; a stalled result output fills the queue first.
// Synchronous reset clears parser state, queue and output valid.
module json_string_unescaper (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  out_byte,
  output logic [1:0]  status,
  output logic [15:0] decoded_length,
  output logic        last
);
  import jsu_pkg::*;

  cfg_t   cfg;
  entry_t fe_entry, q_head;
  logic   fe_push, q_full, q_empty, q_pop, take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_only <= 1'b0;
      cfg.capacity   <= {CAP_W{1'b1}};
    end else if (cfg_write) begin
      if (cfg_index == CFG_COUNT_ONLY) begin
        cfg.count_only <= cfg_data[0];
      end else if (cfg_index == CFG_CAPACITY) begin
        cfg.capacity <= cfg_data[CAP_W-1:0];
      end
    end
  end

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  jsu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .take          (take),
    .text_byte     (text_byte),
    .end_of_buffer (end_of_buffer),
    .push          (fe_push),
    .entry         (fe_entry)
  );

  jsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fe_push),
    .push_entry (fe_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (q_head),
    .empty          (q_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .out_byte       (out_byte),
    .status         (status),
    .decoded_length (decoded_length),
    .last           (last)
  );

endmodule

// ----- sv/jsu_front.sv -----
// Front end: parses raw bytes, checks UTF-8 and escapes, builds result entries.
`include "json_string_unescaper_defines.svh"
module jsu_front (
  input  logic           clk,
  input  logic           rst,
  input  jsu_pkg::cfg_t  cfg,
  input  logic           take,
  input  logic [7:0]     text_byte,
  input  logic           end_of_buffer,
  output logic           push,
  output jsu_pkg::entry_t entry
);
  import jsu_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_BODY, PH_ESC, PH_HEX, PH_LOW_BS, PH_LOW_U, PH_LOW_HEX, PH_UTF8, PH_DRAIN
  } phase_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  phase_t            phase, phase_next, phase_fin;
  logic [15:0]       hacc, hacc_next, hacc_shift;
  logic [1:0]        hcnt, hcnt_next;
  logic [9:0]        hsur, hsur_next;
  logic [23:0]       pend, pend_next;
  logic [1:0]        rem, rem_next;
  logic [LEN_W-1:0]  count, count_next;

  logic              count_clear, bad, done;
  logic              raw_req, cp_req, emit_req, over;
  logic [2:0]        raw_n, cp_n, emit_n;
  logic [3:0][7:0]   raw_bytes, cp_bytes, emit_bytes;
  logic [20:0]       cp;
  logic [3:0]        hex_val;
  logic              hex_ok;
  logic [7:0]        lo, hi;
  logic [LIM_W-1:0]  limit, sum;
  logic              has_term;
  kind_t             term_kind;
  status_t           term_status;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'h0;
    if (text_byte inside {[8'h30:8'h39]}) begin
      hex_val = text_byte[3:0];
    end else if (text_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hex_val = text_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hacc_shift = {hacc[11:0], hex_val};

  always_comb begin
    lo = 8'h80;
    hi = 8'hbf;
    if (pend[23:8] == 16'h0) begin
      case (pend[7:0])
        8'he0:   lo = 8'ha0;
        8'hed:   hi = 8'h9f;
        8'hf0:   lo = 8'h90;
        8'hf4:   hi = 8'h8f;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next  = phase;
    hacc_next   = hacc;
    hcnt_next   = hcnt;
    hsur_next   = hsur;
    pend_next   = pend;
    rem_next    = rem;
    count_clear = 1'b0;
    bad         = 1'b0;
    done        = 1'b0;
    raw_req     = 1'b0;
    raw_n       = 3'd0;
    raw_bytes   = '0;
    cp_req      = 1'b0;
    cp          = '0;
    case (phase)
      PH_IDLE: begin
        if (text_byte == CH_QUOTE) begin
          count_clear = 1'b1;
          hacc_next   = '0;
          hcnt_next   = '0;
          hsur_next   = '0;
          pend_next   = '0;
          rem_next    = '0;
          phase_next  = PH_BODY;
        end else begin
          bad = 1'b1;
        end
      end
      PH_BODY: begin
        if (text_byte == CH_QUOTE) begin
          done       = 1'b1;
          phase_next = PH_IDLE;
        end else if (text_byte == CH_BSLASH) begin
          phase_next = PH_ESC;
        end else if (text_byte < 8'h20) begin
          bad = 1'b1;
        end else if (text_byte < 8'h80) begin
          raw_req      = 1'b1;
          raw_n        = 3'd1;
          raw_bytes[0] = text_byte;
        end else if (text_byte inside {[8'hc2:8'hdf]}) begin
          pend_next  = {16'h0, text_byte};
          rem_next   = 2'd1;
          phase_next = PH_UTF8;
        end else if (text_byte inside {[8'he0:8'hef]}) begin
          pend_next  = {16'h0, text_byte};
          rem_next   = 2'd2;
          phase_next = PH_UTF8;
        end else if (text_byte inside {[8'hf0:8'hf4]}) begin
          pend_next  = {16'h0, text_byte};
          rem_next   = 2'd3;
          phase_next = PH_UTF8;
        end else begin
          bad = 1'b1;
        end
      end
      PH_UTF8: begin
        if (text_byte < lo || text_byte > hi) begin
          bad = 1'b1;
        end else if (rem <= 2'd1) begin
          raw_req = 1'b1;
          if (pend[23:16] != 8'h0) begin
            raw_n     = 3'd4;
            raw_bytes = {text_byte, pend[7:0], pend[15:8], pend[23:16]};
          end else if (pend[15:8] != 8'h0) begin
            raw_n     = 3'd3;
            raw_bytes = {8'h0, text_byte, pend[7:0], pend[15:8]};
          end else begin
            raw_n     = 3'd2;
            raw_bytes = {16'h0, text_byte, pend[7:0]};
          end
          pend_next  = '0;
          rem_next   = '0;
          phase_next = PH_BODY;
        end else begin
          pend_next = {pend[15:0], text_byte};
          rem_next  = rem - 2'd1;
        end
      end
      PH_ESC: begin
        phase_next = PH_BODY;
        cp_req     = 1'b1;
        case (text_byte)
          CH_QUOTE, CH_BSLASH, CH_SLASH: cp = {13'h0, text_byte};
          CH_B: cp = 21'h08;
          CH_F: cp = 21'h0c;
          CH_N: cp = 21'h0a;
          CH_R: cp = 21'h0d;
          CH_T: cp = 21'h09;
          CH_U: begin
            cp_req     = 1'b0;
            hacc_next  = '0;
            hcnt_next  = '0;
            phase_next = PH_HEX;
          end
          default: begin
            cp_req     = 1'b0;
            phase_next = phase;
            bad        = 1'b1;
          end
        endcase
      end
      PH_HEX, PH_LOW_HEX: begin
        if (!hex_ok) begin
          bad = 1'b1;
        end else begin
          hacc_next = hacc_shift;
          if (hcnt != 2'd3) begin
            hcnt_next = hcnt + 2'd1;
          end else begin
            hcnt_next = '0;
            if (phase == PH_HEX) begin
              if (hacc_shift inside {[16'hd800:16'hdbff]}) begin
                hsur_next  = hacc_shift[9:0];
                phase_next = PH_LOW_BS;
              end else if (hacc_shift inside {[16'hdc00:16'hdfff]}) begin
                bad = 1'b1;
              end else begin
                cp_req     = 1'b1;
                cp         = {5'h0, hacc_shift};
                phase_next = PH_BODY;
              end
            end else begin
              if (!(hacc_shift inside {[16'hdc00:16'hdfff]})) begin
                bad = 1'b1;
              end else begin
                cp_req     = 1'b1;
                cp         = 21'h10000 + {1'b0, hsur, hacc_shift[9:0]};
                phase_next = PH_BODY;
              end
            end
          end
        end
      end
      PH_LOW_BS: begin
        if (text_byte == CH_BSLASH) begin
          phase_next = PH_LOW_U;
        end else begin
          bad = 1'b1;
        end
      end
      PH_LOW_U: begin
        if (text_byte == CH_U) begin
          hacc_next  = '0;
          hcnt_next  = '0;
          phase_next = PH_LOW_HEX;
        end else begin
          bad = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cp_bytes = '0;
    if (cp <= 21'h7f) begin
      cp_n        = 3'd1;
      cp_bytes[0] = cp[7:0];
    end else if (cp <= 21'h7ff) begin
      cp_n        = 3'd2;
      cp_bytes[0] = {3'b110, cp[10:6]};
      cp_bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hffff) begin
      cp_n        = 3'd3;
      cp_bytes[0] = {4'b1110, cp[15:12]};
      cp_bytes[1] = {2'b10, cp[11:6]};
      cp_bytes[2] = {2'b10, cp[5:0]};
    end else begin
      cp_n        = 3'd4;
      cp_bytes[0] = {5'b11110, cp[20:18]};
      cp_bytes[1] = {2'b10, cp[17:12]};
      cp_bytes[2] = {2'b10, cp[11:6]};
      cp_bytes[3] = {2'b10, cp[5:0]};
    end
  end

  assign emit_req   = raw_req | cp_req;
  assign emit_n     = raw_req ? raw_n : cp_n;
  assign emit_bytes = raw_req ? raw_bytes : cp_bytes;

  always_comb begin
    if (cfg.count_only || LIM_W'(cfg.capacity) > LIM_W'(CNT_MAX)) begin
      limit = LIM_W'(CNT_MAX);
    end else begin
      limit = LIM_W'(cfg.capacity);
    end
  end

  assign sum  = LIM_W'(count) + LIM_W'(emit_n);
  assign over = emit_req && (sum > limit);

  always_comb begin
    if (count_clear) begin
      count_next = '0;
    end else if (emit_req && !over && !bad) begin
      count_next = sum[LEN_W-1:0];
    end else begin
      count_next = count;
    end
  end

  always_comb begin
    phase_fin   = phase_next;
    has_term    = 1'b0;
    term_kind   = KIND_DONE;
    term_status = ST_OK;
    if (bad || over) begin
      has_term    = 1'b1;
      term_kind   = KIND_ERROR;
      term_status = bad ? ST_MALFORMED : ST_FULL;
      phase_fin   = end_of_buffer ? PH_IDLE : PH_DRAIN;
    end else if (end_of_buffer && phase_next != PH_IDLE) begin
      if (phase_next != PH_DRAIN) begin
        has_term    = 1'b1;
        term_kind   = KIND_ERROR;
        term_status = ST_MALFORMED;
      end
      phase_fin = PH_IDLE;
    end else if (done) begin
      has_term = 1'b1;
    end
  end

  always_comb begin
    entry.ndata       = (emit_req && !over && !bad && !cfg.count_only) ? emit_n : 3'd0;
    entry.bytes       = emit_bytes;
    entry.has_term    = has_term;
    entry.term_kind   = term_kind;
    entry.term_status = term_status;
    entry.base        = OUT_LEN_W'(count);
    entry.fin         = OUT_LEN_W'(count_next);
  end

  assign push = take && (entry.ndata != 3'd0 || has_term);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      hacc  <= '0;
      hcnt  <= '0;
      hsur  <= '0;
      pend  <= '0;
      rem   <= '0;
      count <= '0;
    end else if (take) begin
      phase <= phase_fin;
      hacc  <= hacc_next;
      hcnt  <= hcnt_next;
      hsur  <= hsur_next;
      pend  <= pend_next;
      rem   <= rem_next;
      count <= count_next;
    end
  end

  `JSU_NEVER(a_drain_silent, (phase == PH_DRAIN) && take && push, "result while draining")
  `JSU_ASSERT(a_count_only_no_data, (push && cfg.count_only) |-> (entry.ndata == 3'd0), "data in count mode")

endmodule

// ----- sv/jsu_queue.sv -----
// Short entry queue between the parser and the result serializer.
`include "json_string_unescaper_defines.svh"
module jsu_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jsu_pkg::entry_t  push_entry,
  output logic             full,
  input  logic             pop,
  output jsu_pkg::entry_t  head,
  output logic             empty
);
  import jsu_pkg::*;

  entry_t           slots [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr, rd_ptr;
  logic [Q_AW:0]    cnt;

  assign full  = (cnt == (Q_AW+1)'(Q_DEPTH));
  assign empty = (cnt == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  `JSU_ASSERT(a_q_fill, (push && !pop) |=> (cnt == $past(cnt) + 1'b1), "queue count slip")

endmodule

// ----- sv/jsu_back.sv -----
// Back end: serializes entries into results, one transfer per ready cycle.
`include "json_string_unescaper_defines.svh"
module jsu_back (
  input  logic             clk,
  input  logic             rst,
  input  jsu_pkg::entry_t  head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       result_kind,
  output logic [7:0]       out_byte,
  output logic [1:0]       status,
  output logic [15:0]      decoded_length,
  output logic             last
);
  import jsu_pkg::*;

  logic [2:0] idx;
  logic [2:0] total;
  logic       load, at_last, is_data;

  assign total   = head.ndata + {2'b0, head.has_term};
  assign at_last = ((idx + 3'd1) == total);
  assign is_data = (idx < head.ndata);
  assign load    = !empty && (!out_valid || out_ready);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? 3'd0 : idx + 3'd1;
        last      <= at_last;
        if (is_data) begin
          result_kind    <= KIND_DATA;
          out_byte       <= head.bytes[idx[1:0]];
          status         <= ST_OK;
          decoded_length <= head.base + OUT_LEN_W'(idx) + OUT_LEN_W'(1);
        end else begin
          result_kind    <= head.term_kind;
          out_byte       <= 8'h0;
          status         <= head.term_status;
          decoded_length <= head.fin;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `JSU_ASSERT(a_term_last, (out_valid && result_kind != KIND_DATA) |-> last, "terminal not last")
  `JSU_ASSERT(a_data_ok, (out_valid && result_kind == KIND_DATA) |-> (status == ST_OK), "data with status")

endmodule

// ----- tb/tb_json_string_unescaper.sv -----
// Self-checking testbench for the JSON string unescaper: random and directed text, scoreboard.
module tb_json_string_unescaper;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  typedef enum logic [3:0] {
    S_WAIT_QUOTE, S_BODY, S_ESCAPE, S_HEX, S_LOW_BSLASH, S_LOW_U, S_LOW_HEX, S_UTF8, S_SKIP
  } scan_state_t;

  typedef struct {
    logic [7:0] data;
    logic       eob;
  } text_item_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    status_t     st;
    logic [15:0] len;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [0:0]  cfg_index = CFG_COUNT_ONLY;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  text_byte = '0;
  logic        end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic [15:0] decoded_length;
  logic        last;

  text_item_t  text_queue[$];
  result_t     expected_results[$];
  logic [7:0]  draft[$];
  int unsigned items_queued = 0;
  int unsigned errors = 0;
  int unsigned tx_idle_pct = 20;
  int unsigned rx_idle_pct = 66;
  string       esc_set = "\"\\/bfnrt";

  // predictor state and register copies
  scan_state_t scan_state = S_WAIT_QUOTE;
  logic [15:0] esc_hex = '0;
  logic [1:0]  esc_hex_cnt = '0;
  logic [9:0]  hi_half = '0;
  logic [23:0] utf8_held = '0;
  logic [1:0]  utf8_left = '0;
  int unsigned byte_count = 0;
  logic        cfg_count_only_q = 1'b0;
  logic [15:0] cfg_capacity_q = 16'hffff;

  json_string_unescaper DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .text_byte(text_byte), .end_of_buffer(end_of_buffer),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .out_byte(out_byte), .status(status),
    .decoded_length(decoded_length), .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void add_result(kind_t k, logic [7:0] d, status_t s);
    expected_results.push_back('{kind: k, data: d, st: s, len: byte_count[15:0], last: 1'b0});
  endfunction

  function automatic bit put_bytes(logic [3:0][7:0] seq, int unsigned cnt);
    int unsigned ceiling;
    ceiling = 32'hffff;
    if (!cfg_count_only_q && cfg_capacity_q < ceiling) ceiling = cfg_capacity_q;
    if (byte_count + cnt > ceiling) return 1'b0;
    for (int i = 0; i < cnt; i++) begin
      byte_count++;
      if (!cfg_count_only_q) add_result(KIND_DATA, seq[i], ST_OK);
    end
    return 1'b1;
  endfunction

  function automatic bit put_code_point(logic [20:0] cp);
    logic [3:0][7:0] seq;
    int unsigned n;
    seq = '0;
    if (cp <= 21'h7f) begin
      seq[0] = cp[7:0];
      n = 1;
    end else if (cp <= 21'h7ff) begin
      seq[0] = {3'b110, cp[10:6]};
      seq[1] = {2'b10, cp[5:0]};
      n = 2;
    end else if (cp <= 21'hffff) begin
      seq[0] = {4'b1110, cp[15:12]};
      seq[1] = {2'b10, cp[11:6]};
      seq[2] = {2'b10, cp[5:0]};
      n = 3;
    end else begin
      seq[0] = {5'b11110, cp[20:18]};
      seq[1] = {2'b10, cp[17:12]};
      seq[2] = {2'b10, cp[11:6]};
      seq[3] = {2'b10, cp[5:0]};
      n = 4;
    end
    return put_bytes(seq, n);
  endfunction

  function automatic int nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void decode_text_byte(logic [7:0] b, logic eob);
    status_t         fault;
    int              hv;
    int              held;
    int unsigned     n0;
    logic [7:0]      lo, hi;
    logic [3:0][7:0] seq;
    n0 = expected_results.size();
    fault = ST_OK;
    case (scan_state)
      S_WAIT_QUOTE: begin
        if (b == "\"") begin
          byte_count = 0;
          esc_hex = '0;
          esc_hex_cnt = '0;
          hi_half = '0;
          utf8_held = '0;
          utf8_left = '0;
          scan_state = S_BODY;
        end else begin
          fault = ST_MALFORMED;
        end
      end
      S_BODY: begin
        if (b == "\"") begin
          add_result(KIND_DONE, 8'h00, ST_OK);
          scan_state = S_WAIT_QUOTE;
        end else if (b == "\\") begin
          scan_state = S_ESCAPE;
        end else if (b < 8'h20) begin
          fault = ST_MALFORMED;
        end else if (b < 8'h80) begin
          if (!put_bytes({24'h0, b}, 1)) fault = ST_FULL;
        end else if (b >= 8'hc2 && b <= 8'hdf) begin
          utf8_held = {16'h0, b};
          utf8_left = 2'd1;
          scan_state = S_UTF8;
        end else if (b >= 8'he0 && b <= 8'hef) begin
          utf8_held = {16'h0, b};
          utf8_left = 2'd2;
          scan_state = S_UTF8;
        end else if (b >= 8'hf0 && b <= 8'hf4) begin
          utf8_held = {16'h0, b};
          utf8_left = 2'd3;
          scan_state = S_UTF8;
        end else begin
          fault = ST_MALFORMED;
        end
      end
      S_UTF8: begin
        lo = 8'h80;
        hi = 8'hbf;
        if (utf8_held <= 24'hff) begin
          case (utf8_held[7:0])
            8'he0: lo = 8'ha0;
            8'hed: hi = 8'h9f;
            8'hf0: lo = 8'h90;
            8'hf4: hi = 8'h8f;
            default: ;
          endcase
        end
        if (b < lo || b > hi) begin
          fault = ST_MALFORMED;
        end else if (utf8_left <= 2'd1) begin
          held = (utf8_held > 24'hffff) ? 3 : ((utf8_held > 24'hff) ? 2 : 1);
          seq = '0;
          for (int i = 0; i < held; i++) seq[i] = 8'(utf8_held >> (8 * (held - 1 - i)));
          seq[held] = b;
          if (!put_bytes(seq, held + 1)) fault = ST_FULL;
          utf8_held = '0;
          utf8_left = '0;
          scan_state = S_BODY;
        end else begin
          utf8_held = {utf8_held[15:0], b};
          utf8_left = utf8_left - 2'd1;
        end
      end
      S_ESCAPE: begin
        case (b)
          "\"", "\\", "/": begin
            if (!put_code_point({13'h0, b})) fault = ST_FULL;
            scan_state = S_BODY;
          end
          "b": begin
            if (!put_code_point(21'h08)) fault = ST_FULL;
            scan_state = S_BODY;
          end
          "f": begin
            if (!put_code_point(21'h0c)) fault = ST_FULL;
            scan_state = S_BODY;
          end
          "n": begin
            if (!put_code_point(21'h0a)) fault = ST_FULL;
            scan_state = S_BODY;
          end
          "r": begin
            if (!put_code_point(21'h0d)) fault = ST_FULL;
            scan_state = S_BODY;
          end
          "t": begin
            if (!put_code_point(21'h09)) fault = ST_FULL;
            scan_state = S_BODY;
          end
          "u": begin
            esc_hex = '0;
            esc_hex_cnt = '0;
            scan_state = S_HEX;
          end
          default: fault = ST_MALFORMED;
        endcase
      end
      S_HEX, S_LOW_HEX: begin
        hv = nibble_of(b);
        if (hv < 0) begin
          fault = ST_MALFORMED;
        end else begin
          esc_hex = {esc_hex[11:0], hv[3:0]};
          if (esc_hex_cnt < 2'd3) begin
            esc_hex_cnt = esc_hex_cnt + 2'd1;
          end else begin
            esc_hex_cnt = '0;
            if (scan_state == S_HEX) begin
              if (esc_hex >= 16'hd800 && esc_hex <= 16'hdbff) begin
                hi_half = esc_hex[9:0];
                scan_state = S_LOW_BSLASH;
              end else if (esc_hex >= 16'hdc00 && esc_hex <= 16'hdfff) begin
                fault = ST_MALFORMED;
              end else begin
                if (!put_code_point({5'h0, esc_hex})) fault = ST_FULL;
                scan_state = S_BODY;
              end
            end else begin
              if (esc_hex < 16'hdc00 || esc_hex > 16'hdfff) begin
                fault = ST_MALFORMED;
              end else begin
                if (!put_code_point(21'h10000 + {hi_half, esc_hex[9:0]})) fault = ST_FULL;
                scan_state = S_BODY;
              end
            end
          end
        end
      end
      S_LOW_BSLASH: begin
        if (b == "\\") scan_state = S_LOW_U;
        else fault = ST_MALFORMED;
      end
      S_LOW_U: begin
        if (b == "u") begin
          esc_hex = '0;
          esc_hex_cnt = '0;
          scan_state = S_LOW_HEX;
        end else begin
          fault = ST_MALFORMED;
        end
      end
      default: ;
    endcase
    if (fault != ST_OK) begin
      add_result(KIND_ERROR, 8'h00, fault);
      scan_state = eob ? S_WAIT_QUOTE : S_SKIP;
    end else if (eob && scan_state != S_WAIT_QUOTE) begin
      if (scan_state != S_SKIP) add_result(KIND_ERROR, 8'h00, ST_MALFORMED);
      scan_state = S_WAIT_QUOTE;
    end
    if (expected_results.size() > n0) expected_results[$].last = 1'b1;
  endfunction

  always @(posedge clk) begin : drive_text
    text_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_text_byte(text_byte, end_of_buffer);
      if (!in_valid || in_ready) begin
        if (text_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = text_queue.pop_front();
          in_valid <= 1'b1;
          text_byte <= nxt.data;
          end_of_buffer <= nxt.eob;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: kind %0d byte 0x%0h", result_kind, out_byte);
        errors++;
      end else begin
        want = expected_results.pop_front();
        compare_field("result_kind", want.kind, result_kind);
        compare_field("out_byte", want.data, out_byte);
        compare_field("status", want.st, status);
        compare_field("decoded_length", want.len, decoded_length);
        compare_field("last", want.last, last);
      end
    end
  end

  task automatic add_byte(logic [7:0] b, logic eob);
    text_queue.push_back('{data: b, eob: eob});
    items_queued++;
  endtask

  task automatic add_text(string s, bit eob_last);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], eob_last && (i == s.len() - 1));
  endtask

  task automatic flush_draft(bit eob_last);
    foreach (draft[i]) add_byte(draft[i], eob_last && (i == draft.size() - 1));
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
    if (nib < 4'd10) return "0" + nib;
    return (upper ? "A" : "a") + nib - 8'd10;
  endfunction

  task automatic draft_u_escape(logic [15:0] v);
    draft.push_back("\\");
    draft.push_back("u");
    for (int i = 3; i >= 0; i--) draft.push_back(hex_char(v[4*i +: 4], 1'($urandom_range(1))));
  endtask

  task automatic draft_piece();
    logic [7:0]  c, lead, lo, hi;
    logic [15:0] v;
    case ($urandom_range(6))
      0, 1: begin
        do c = 8'($urandom_range(8'h20, 8'h7e)); while (c == "\"" || c == "\\");
        draft.push_back(c);
      end
      2: begin
        draft.push_back("\\");
        draft.push_back(esc_set[$urandom_range(7)]);
      end
      3: begin
        case ($urandom_range(2))
          0: v = 16'($urandom_range(16'h007f));
          1: v = 16'($urandom_range(16'h0080, 16'h07ff));
          default: do v = 16'($urandom_range(16'h0800, 16'hffff));
                   while (v >= 16'hd800 && v <= 16'hdfff);
        endcase
        draft_u_escape(v);
      end
      4: begin
        draft_u_escape(16'($urandom_range(16'hd800, 16'hdbff)));
        draft_u_escape(16'($urandom_range(16'hdc00, 16'hdfff)));
      end
      5: begin
        draft.push_back(8'($urandom_range(8'hc2, 8'hdf)));
        draft.push_back(8'($urandom_range(8'h80, 8'hbf)));
      end
      default: begin
        lead = 8'($urandom_range(8'he0, 8'hf4));
        lo = 8'h80;
        hi = 8'hbf;
        case (lead)
          8'he0: lo = 8'ha0;
          8'hed: hi = 8'h9f;
          8'hf0: lo = 8'h90;
          8'hf4: hi = 8'h8f;
          default: ;
        endcase
        draft.push_back(lead);
        draft.push_back(8'($urandom_range(lo, hi)));
        repeat ((lead >= 8'hf0) ? 2 : 1) draft.push_back(8'($urandom_range(8'h80, 8'hbf)));
      end
    endcase
  endtask

  task automatic add_random_text(int unsigned target);
    int unsigned start, mode, pos;
    start = items_queued;
    while (items_queued - start < target) begin
      mode = $urandom_range(99);
      draft.delete();
      if (mode < 12) begin
        repeat ($urandom_range(1, 4)) draft.push_back(8'($urandom_range(255)));
        foreach (draft[i]) add_byte(draft[i], (i == draft.size() - 1) || ($urandom_range(3) == 0));
      end else begin
        draft.push_back("\"");
        repeat ($urandom_range(5)) draft_piece();
        draft.push_back("\"");
        if (mode < 32) begin
          pos = $urandom_range(draft.size() - 1);
          if ($urandom_range(1)) draft[pos] = 8'($urandom_range(255));
          else while (draft.size() > pos + 1) void'(draft.pop_back());
          flush_draft(1'b1);
        end else begin
          flush_draft(1'($urandom_range(1)));
        end
      end
    end
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_COUNT_ONLY) cfg_count_only_q = val[0];
    else cfg_capacity_q = val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (text_queue.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_reg(CFG_COUNT_ONLY, 16'h0000);
    write_reg(CFG_CAPACITY, 16'hffff);

    add_text("\"", 1'b1);
    add_text("x", 1'b0);
    add_byte(8'hff, 1'b1);
    add_text("\"A\\n\"", 1'b0);
    add_text("\"\\uDBFF\\uDFFF", 1'b1);
    add_text("\"", 1'b0);
    add_byte(8'hf4, 1'b0);
    add_byte(8'h8f, 1'b0);
    add_byte(8'hbf, 1'b0);
    add_byte(8'hbf, 1'b0);
    add_text("\"", 1'b1);
    add_random_text(30);
    wait_idle();

    tx_idle_pct = 66;
    rx_idle_pct = 20;
    write_reg(CFG_CAPACITY, 16'h0000);
    add_random_text(10);
    wait_idle();
    write_reg(CFG_CAPACITY, 16'($urandom_range(2, 12)));
    add_random_text(20);
    wait_idle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_COUNT_ONLY, 16'h0001);
    write_reg(CFG_CAPACITY, 16'h0000);
    add_random_text(15);
    wait_idle();
    add_random_text(15);
    wait_idle();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
